// File: rtl/core/edf_tick_scheduler_macros.svh
// assertion macros for the edf tick scheduler
// used by rtl/core files that carry concurrent checks, no other dependencies
`ifndef EDF_TICK_SCHEDULER_MACROS_SVH
`define EDF_TICK_SCHEDULER_MACROS_SVH

// condition implies consequence in the same cycle
`define EDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define EDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/edf_pkg.sv
// shared types, codes and defaults of the edf tick scheduler
// no dependencies; used by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

	// default number of task slots
	localparam int MAX_TASKS_DEF = 8;

	// command function codes
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// reset value of the task count register
	localparam logic [3:0] TASK_COUNT_RESET = 4'd1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPLY
	} state_t;

	// one command transfer
	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  task_index;
		logic [15:0] exec_time;
		logic [15:0] period_len;
		logic [15:0] job_count;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic [2:0]  running_task;
		logic        idle;
		logic        job_done;
		logic [7:0]  miss_mask;
		logic [15:0] miss_count;
		logic [31:0] wait_count;
	} out_item_t;

	// data handed from cell to cell during the walk
	typedef struct packed {
		logic        found;
		logic [15:0] best_dl;
		logic [15:0] miss_count;
		logic [31:0] wait_count;
	} walk_pkt_t;

	// controls broadcast from the controller to every cell
	typedef struct packed {
		logic       walk_en;
		logic       apply_tick;
		logic       apply_load;
		logic       found;
		logic [3:0] task_count;
		in_item_t   item;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/edf_tick_scheduler.sv
// edf tick scheduler: a load goes from accept to the apply state and then the result
// strobe; tick and read first walk the search and query data down the chain of MAX_TASKS
// slot cells, one cell a cycle, then apply. a new command is taken in the strobe cycle,
// so no new command is taken before the last one is through.
// results cannot be stalled. asynchronous reset clears all slots, sets task count to 1
// and returns the sequencer to idle at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module edf_tick_scheduler #(
	parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  edf_pkg::in_item_t  cmd,
	input  wire                cfg_we,
	input  wire [3:0]          cfg_wdata,
	output edf_pkg::out_item_t result,
	output logic               res_valid
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	edf_pkg::cell_ctrl_t ctrl;
	edf_pkg::walk_pkt_t  pkt   [MAX_TASKS+1];
	logic [IW-1:0]       run_c [MAX_TASKS+1];
	logic [IW-1:0]       run_bcast;
	logic [MAX_TASKS-1:0] done_vec, miss_vec;
	logic [7:0]          miss_bits;

	// chain entry: nothing found yet, bound all ones
	assign pkt[0]   = '{found: 1'b0, best_dl: 16'hFFFF, miss_count: 16'd0, wait_count: 32'd0};
	assign run_c[0] = '0;

	// row of slot cells
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		edf_cell #(
			.INDEX(i),
			.IW   (IW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.run     (run_bcast),
			.pkt_prev(pkt[i]),
			.run_prev(run_c[i]),
			.pkt_next(pkt[i+1]),
			.run_next(run_c[i+1]),
			.job_done(done_vec[i]),
			.missed  (miss_vec[i])
		);
	end

	// miss bits exist only for the first eight slots
	for (genvar j = 0; j < 8; j++) begin : g_mask
		if (j < MAX_TASKS) begin : g_has
			assign miss_bits[j] = miss_vec[j];
		end else begin : g_none
			assign miss_bits[j] = 1'b0;
		end
	end

	// sequencer and result register
	edf_ctrl #(
		.MAX_TASKS(MAX_TASKS),
		.IW       (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.last_pkt (pkt[MAX_TASKS]),
		.last_run (run_c[MAX_TASKS]),
		.any_done (|done_vec),
		.miss_bits(miss_bits),
		.ctrl     (ctrl),
		.run_bcast(run_bcast),
		.result   (result),
		.res_valid(res_valid)
	);

endmodule

`default_nettype wire

// File: rtl/core/edf_cell.sv
// one task slot of the scheduler chain: slot state, walk stage and tick update
// depends on edf_pkg
`timescale 1ns / 1ps
`default_nettype none

module edf_cell #(
	parameter int INDEX = 0,
	parameter int IW    = 3
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  edf_pkg::cell_ctrl_t ctrl,
	input  wire [IW-1:0]        run,
	input  edf_pkg::walk_pkt_t  pkt_prev,
	input  wire [IW-1:0]        run_prev,
	output edf_pkg::walk_pkt_t  pkt_next,
	output logic [IW-1:0]       run_next,
	output logic                job_done,
	output logic                missed
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	// slot state
	logic [15:0] rem_q, dl_q, phase_q, exec_q, period_q, jobs_q, miss_q;
	logic [31:0] wait_q;

	// walk stage
	edf_pkg::walk_pkt_t pkt_q;
	logic [IW-1:0]      run_q;

	logic active, index_hit, eligible, take;
	logic is_run, wait_hit, run_done, run_miss, other_miss, miss_hit, reload;
	logic [15:0] rem_dec, rem_nx, dl_nx, phase_nx, jobs_nx, miss_nx;
	logic [31:0] wait_nx;
	edf_pkg::walk_pkt_t pkt_d;
	logic [IW-1:0]      run_d;

	// slot in use and command index match
	assign active    = (INDEX == 0) || (32'(INDEX) < {28'd0, ctrl.task_count});
	assign index_hit = (INDEX < 8) && (ctrl.item.task_index == 3'(INDEX));

	// walk: earliest deadline so far, and counters of the queried slot
	always_comb begin
		eligible = active && (rem_q != 16'd0) && (jobs_q != 16'd0);
		take     = eligible && (!pkt_prev.found || (dl_q < pkt_prev.best_dl));
		pkt_d    = pkt_prev;
		run_d    = run_prev;
		if (take) begin
			pkt_d.found   = 1'b1;
			pkt_d.best_dl = dl_q;
			run_d         = MY_IDX;
		end
		if (index_hit) begin
			pkt_d.miss_count = miss_q;
			pkt_d.wait_count = wait_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.walk_en) begin
			pkt_q <= pkt_d;
			run_q <= run_d;
		end
	end

	assign pkt_next = pkt_q;
	assign run_next = run_q;

	// tick update of this slot
	always_comb begin
		is_run     = ctrl.found && (run == MY_IDX);
		rem_dec    = is_run ? rem_q - 16'd1 : rem_q;
		wait_hit   = !is_run && (rem_q != 16'd0) && (jobs_q != 16'd0)
			&& ({1'b0, phase_q} != ({1'b0, period_q} + 17'd1));
		run_done   = is_run && (rem_dec == 16'd0);
		run_miss   = is_run && (rem_dec != 16'd0) && (dl_q == 16'd1);
		other_miss = !is_run && (rem_q != 16'd0) && (dl_q <= 16'd1) && (jobs_q != 16'd0);
		miss_hit   = run_miss || other_miss;
		jobs_nx    = ((run_done || miss_hit) && (jobs_q != 16'd0)) ? jobs_q - 16'd1 : jobs_q;
		miss_nx    = (miss_hit && (miss_q != 16'hFFFF)) ? miss_q + 16'd1 : miss_q;
		wait_nx    = (wait_hit && (wait_q != 32'hFFFF_FFFF)) ? wait_q + 32'd1 : wait_q;
		reload     = (({1'b0, phase_q} + 17'd1) == {1'b0, period_q});
		if (reload) begin
			dl_nx    = period_q;
			rem_nx   = exec_q;
			phase_nx = 16'd0;
		end else begin
			dl_nx    = (dl_q != 16'd0) ? dl_q - 16'd1 : 16'd0;
			rem_nx   = rem_dec;
			phase_nx = phase_q + 16'd1;
		end
	end

	assign job_done = ctrl.apply_tick && active && run_done;
	assign missed   = ctrl.apply_tick && active && miss_hit;

	// slot registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 16'd0;
			dl_q     <= 16'd0;
			phase_q  <= 16'd0;
			exec_q   <= 16'd0;
			period_q <= 16'd0;
			jobs_q   <= 16'd0;
			miss_q   <= 16'd0;
			wait_q   <= 32'd0;
		end else if (ctrl.apply_load && index_hit) begin
			exec_q   <= ctrl.item.exec_time;
			period_q <= ctrl.item.period_len;
			jobs_q   <= ctrl.item.job_count;
			rem_q    <= ctrl.item.exec_time;
			dl_q     <= ctrl.item.period_len;
			phase_q  <= 16'd0;
			miss_q   <= 16'd0;
			wait_q   <= 32'd0;
		end else if (ctrl.apply_tick && active) begin
			rem_q   <= rem_nx;
			dl_q    <= dl_nx;
			phase_q <= phase_nx;
			jobs_q  <= jobs_nx;
			miss_q  <= miss_nx;
			wait_q  <= wait_nx;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/edf_ctrl.sv
// command sequencer: task count register, walk counter, broadcast and result register
// depends on edf_pkg and edf_tick_scheduler_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "edf_tick_scheduler_macros.svh"

module edf_ctrl #(
	parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
	parameter int IW        = 3
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  edf_pkg::in_item_t   cmd,
	input  wire                 cfg_we,
	input  wire [3:0]           cfg_wdata,
	input  edf_pkg::walk_pkt_t  last_pkt,
	input  wire [IW-1:0]        last_run,
	input  wire                 any_done,
	input  wire [7:0]           miss_bits,
	output edf_pkg::cell_ctrl_t ctrl,
	output logic [IW-1:0]       run_bcast,
	output edf_pkg::out_item_t  result,
	output logic                res_valid
);

	localparam int RW = (IW > 3) ? IW : 3;
	localparam logic [IW-1:0] CNT_LAST = IW'(MAX_TASKS - 1);

	edf_pkg::state_t    state_q, state_d;
	edf_pkg::in_item_t  item_q;
	edf_pkg::out_item_t result_q, result_d;
	logic [IW-1:0]      cnt_q;
	logic [3:0]         task_count_q;
	logic               res_valid_q;
	logic [RW-1:0]      run_wide;
	logic               accept, multi_cycle;

	assign accept      = start && !busy;
	assign multi_cycle = (cmd.func == edf_pkg::FUNC_TICK) || (cmd.func == edf_pkg::FUNC_READ);

	// task count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= edf_pkg::TASK_COUNT_RESET;
		end else if (cfg_we) begin
			task_count_q <= cfg_wdata;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			edf_pkg::ST_IDLE: begin
				if (start) begin
					state_d = multi_cycle ? edf_pkg::ST_WALK : edf_pkg::ST_APPLY;
				end
			end
			edf_pkg::ST_WALK: begin
				if (cnt_q == CNT_LAST) begin
					state_d = edf_pkg::ST_APPLY;
				end
			end
			edf_pkg::ST_APPLY: state_d = edf_pkg::ST_IDLE;
			default:           state_d = edf_pkg::ST_IDLE;
		endcase
	end

	// state outputs and cell broadcast
	always_comb begin
		busy            = (state_q != edf_pkg::ST_IDLE);
		ctrl.walk_en    = (state_q == edf_pkg::ST_WALK);
		ctrl.apply_tick = (state_q == edf_pkg::ST_APPLY) && (item_q.func == edf_pkg::FUNC_TICK);
		ctrl.apply_load = (state_q == edf_pkg::ST_APPLY) && (item_q.func == edf_pkg::FUNC_LOAD);
		ctrl.found      = last_pkt.found;
		ctrl.task_count = task_count_q;
		ctrl.item       = item_q;
	end

	assign run_bcast = last_run;

	// state and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == edf_pkg::ST_WALK) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// result formatting
	always_comb begin
		run_wide = RW'(last_run);
		result_d = '0;
		case (item_q.func)
			edf_pkg::FUNC_TICK: begin
				result_d.running_task = last_pkt.found ? run_wide[2:0] : 3'd0;
				result_d.idle         = !last_pkt.found;
				result_d.job_done     = any_done;
				result_d.miss_mask    = miss_bits;
			end
			edf_pkg::FUNC_READ: begin
				result_d.miss_count = last_pkt.miss_count;
				result_d.wait_count = last_pkt.wait_count;
			end
			default: result_d = '0;
		endcase
	end

	// result transfer register, one cycle strobe
	always_ff @(posedge clk) begin
		if (state_q == edf_pkg::ST_APPLY) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == edf_pkg::ST_APPLY);
		end
	end

	assign result    = result_q;
	assign res_valid = res_valid_q;

	// checks
	`EDF_ASSERT_NEXT(a_strobe_single, clk, arst_n, res_valid_q, !res_valid_q, "result strobe held")
	`EDF_ASSERT_NEXT(a_apply_strobe, clk, arst_n, state_q == edf_pkg::ST_APPLY, res_valid_q && !busy, "apply without transfer")
	`EDF_ASSERT_NOW(a_idle_tick, clk, arst_n, res_valid_q && result_q.idle, !result_q.job_done && (result_q.running_task == 3'd0), "idle tick with a runner")
	`EDF_ASSERT_NOW(a_walk_bound, clk, arst_n, state_q == edf_pkg::ST_WALK, cnt_q <= CNT_LAST, "walk counter overrun")

endmodule

`default_nettype wire
